// ===== hdl/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared constants, register indexes and a helper for the bit-field pixel
// unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpu_pkg;

   localparam int WORD_W   = 32;
   localparam int CHAN_W   = 8;
   localparam int NUM_W    = WORD_W + CHAN_W;
   localparam int SHIFT_W  = $clog2(WORD_W);
   localparam int CSR_IDX_W = 3;
   localparam int NUM_LANES = 4;
   // extract, scale, then one stage per quotient bit
   localparam int NUM_STAGES = 2 + CHAN_W;
   localparam logic [CHAN_W-1:0] CHANNEL_FULL = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RED_MASK   = 3'd0,
      REG_GREEN_MASK = 3'd1,
      REG_BLUE_MASK  = 3'd2,
      REG_ALPHA_MASK = 3'd3,
      REG_WIDE_PIX   = 3'd4
   } csr_index_type;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   function automatic logic [SHIFT_W-1:0] lowest_set_bit(input logic [WORD_W-1:0] m);
      logic [SHIFT_W-1:0] k;
      k = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            k = SHIFT_W'(i);
         end
      end
      return k;
   endfunction

endpackage

// ===== hdl/bitfield_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// bitfield_pixel_unpacker
// Splits a packed pixel word into red, green, blue and alpha bytes using four
// configured channel masks, each field scaled to 0..255.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall with req_pixel_word; results leave
//   on rsp_valid/rsp_stall with one byte per channel plus rsp_has_alpha.
//   Masks and the pixel width are written through csr_write_enable,
//   csr_index and csr_data; the user must write them only while no request
//   is in flight, as the block itself does not enforce this.
//   Throughput: one pixel per cycle while req_stall is low; four lanes run
//   side by side, each with an extract stage, a scale stage and an 8-stage
//   divider (one quotient bit per stage), merged into one output register.
//   A stalled receiver holds the output; stages behind it keep filling until
//   the pipeline is full, then req_stall rises.
//   Reset clears all valid bits, zeroes the masks and selects 32-bit pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitfield_pixel_unpacker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bpu_pkg::WORD_W-1:0]        req_pixel_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bpu_pkg::CHAN_W-1:0]        rsp_red,
   output logic [bpu_pkg::CHAN_W-1:0]        rsp_green,
   output logic [bpu_pkg::CHAN_W-1:0]        rsp_blue,
   output logic [bpu_pkg::CHAN_W-1:0]        rsp_alpha,
   output logic                              rsp_has_alpha,
   input  logic                              csr_write_enable,
   input  logic [bpu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpu_pkg::WORD_W-1:0]        csr_data
);
   import bpu_pkg::*;

   logic [WORD_W-1:0]     mask_ff [NUM_LANES];
   logic                  wide_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic                  rsp_valid_ff;
   logic [CHAN_W-1:0]     level_ff [NUM_LANES];
   logic                  has_alpha_ff;

   stage_en_type          stage_en;
   logic                  out_en;
   logic [WORD_W-1:0]     word_eff;
   logic [CHAN_W-1:0]     level [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) mask_ff[i] <= '0;
         wide_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RED_MASK:   mask_ff[0] <= csr_data;
            REG_GREEN_MASK: mask_ff[1] <= csr_data;
            REG_BLUE_MASK:  mask_ff[2] <= csr_data;
            REG_ALPHA_MASK: mask_ff[3] <= csr_data;
            REG_WIDE_PIX:   wide_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_en = !rsp_valid_ff || !rsp_stall;
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_en;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      word_eff = wide_ff ? req_pixel_word : {{(WORD_W/2){1'b0}}, req_pixel_word[WORD_W/2-1:0]};
   end

   assign req_stall = !stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_en[0]) valid_ff[0] <= req_valid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (stage_en[s]) valid_ff[s] <= valid_ff[s-1];
         end
         if (out_en) rsp_valid_ff <= valid_ff[NUM_STAGES-1];
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      bpu_lane u_lane (
         .clock      (clock),
         .stage_en   (stage_en),
         .pixel_word (word_eff),
         .mask       (mask_ff[l]),
         .level      (level[l])
      );
   end

   // merge lanes into the output register
   always_ff @(posedge clock) begin
      if (out_en) begin
         for (int i = 0; i < NUM_LANES; i++) level_ff[i] <= level[i];
         has_alpha_ff <= (mask_ff[3] != '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = level_ff[0];
   assign rsp_green     = level_ff[1];
   assign rsp_blue      = level_ff[2];
   assign rsp_alpha     = level_ff[3];
   assign rsp_has_alpha = has_alpha_ff;

   a_no_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_alpha) |-> (rsp_alpha == '0))
      else $error("alpha byte nonzero without alpha");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("request stalled with empty front stage");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && valid_ff == '0))
      else $error("valid bits not cleared by reset");

endmodule

// ===== hdl/bpu_lane.sv =====
// ----------------------------------------------------------------------------
// bpu_lane
// One channel: field extraction, scaling by 255 and a pipelined restoring
// divider that yields one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpu_lane (
   input  logic                          clock,
   input  bpu_pkg::stage_en_type         stage_en,
   input  logic [bpu_pkg::WORD_W-1:0]    pixel_word,
   input  logic [bpu_pkg::WORD_W-1:0]    mask,
   output logic [bpu_pkg::CHAN_W-1:0]    level
);
   import bpu_pkg::*;

   logic [WORD_W-1:0]  field_ff;
   logic [WORD_W-1:0]  span_ff [1:NUM_STAGES-1];
   logic [WORD_W-1:0]  span0_ff;
   logic [NUM_W-1:0]   num_ff  [1:NUM_STAGES-1];
   logic [CHAN_W-1:0]  quo_ff  [1:NUM_STAGES-1];

   logic [SHIFT_W-1:0] sh;
   logic [WORD_W-1:0]  field_in;
   logic [WORD_W-1:0]  span_in;

   always_comb begin
      sh       = lowest_set_bit(mask);
      field_in = (pixel_word & mask) >> sh;
      // zero mask: all-ones divisor with a zero field yields 0
      span_in  = (mask == '0) ? '1 : (mask >> sh);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         field_ff <= field_in;
         span0_ff <= span_in;
      end
      if (stage_en[1]) begin
         num_ff[1]  <= {field_ff, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, field_ff};
         span_ff[1] <= span0_ff;
         quo_ff[1]  <= '0;
      end
   end

   for (genvar s = 2; s < NUM_STAGES; s++) begin : g_div
      localparam int BIT = NUM_STAGES - 1 - s;
      logic [NUM_W-1:0] sub;
      logic             take;
      always_comb begin
         sub  = {{CHAN_W{1'b0}}, span_ff[s-1]} << BIT;
         take = (num_ff[s-1] >= sub);
      end
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            num_ff[s]  <= take ? (num_ff[s-1] - sub) : num_ff[s-1];
            span_ff[s] <= span_ff[s-1];
            quo_ff[s]  <= quo_ff[s-1] | (CHAN_W'(take) << BIT);
         end
      end
   end

   assign level = quo_ff[NUM_STAGES-1];

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit-field pixel unpacker: writes channel masks
// and pixel width, streams pixel words under several idle/stall mixes and
// compares every output byte with a local scaling predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bpu_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              has_alpha;
   } pixel_bytes_type;

   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_pixel_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CHAN_W-1:0]    rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic                 rsp_has_alpha;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;

   logic [WORD_W-1:0] mask_red, mask_green, mask_blue, mask_alpha;
   logic              pix_wide;
   pixel_bytes_type   expected_pixels[$];
   int                error_count;
   int                idle_pct;
   int                stall_pct;
   int                quiet_cycles;

   bitfield_pixel_unpacker dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [CHAN_W-1:0] scale_field(logic [WORD_W-1:0] word,
                                                     logic [WORD_W-1:0] m);
      int               sh;
      logic [WORD_W-1:0] field, span;
      logic [63:0]      prod;
      if (m == '0) return '0;
      sh = 0;
      while (!m[sh]) sh++;
      field = (word & m) >> sh;
      span = m >> sh;
      prod = 64'(CHANNEL_FULL) * 64'(field) / 64'(span);
      return prod[CHAN_W-1:0];
   endfunction

   function automatic pixel_bytes_type predict_pixel(logic [WORD_W-1:0] word);
      pixel_bytes_type p;
      if (!pix_wide) word[WORD_W-1:16] = '0;
      p.red = scale_field(word, mask_red);
      p.green = scale_field(word, mask_green);
      p.blue = scale_field(word, mask_blue);
      p.has_alpha = (mask_alpha != '0);
      p.alpha = p.has_alpha ? scale_field(word, mask_alpha) : '0;
      return p;
   endfunction

   // drops the request valid
   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [WORD_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         REG_RED_MASK: begin
            mask_red = value;
         end
         REG_GREEN_MASK: begin
            mask_green = value;
         end
         REG_BLUE_MASK: begin
            mask_blue = value;
         end
         REG_ALPHA_MASK: begin
            mask_alpha = value;
         end
         REG_WIDE_PIX: begin
            pix_wide = value[0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_format(logic [WORD_W-1:0] r, logic [WORD_W-1:0] g,
                             logic [WORD_W-1:0] b, logic [WORD_W-1:0] a, logic w);
      drop_valid();
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(REG_RED_MASK, r);
      write_reg(REG_GREEN_MASK, g);
      write_reg(REG_BLUE_MASK, b);
      write_reg(REG_ALPHA_MASK, a);
      write_reg(REG_WIDE_PIX, {31'b0, w});
      csr_write_enable <= 1'b0;
   endtask

   // valid stays high after acceptance so requests can follow back to back
   task automatic send_pixel(logic [WORD_W-1:0] word);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pixels.push_back(predict_pixel(word));
   endtask

   function automatic logic [WORD_W-1:0] random_mask();
      int lo, len;
      case ($urandom_range(5))
         0: return '0;
         1: return $urandom();
         2: return 32'hFFFF_FFFF;
         default: begin
            lo = $urandom_range(31);
            len = $urandom_range(1, 32 - lo);
            return ((len == 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 1)) << lo;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected response %h %h %h %h %b", $time,
                        rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_has_alpha);
               error_count++;
            end else begin
               pixel_bytes_type e;
               e = expected_pixels.pop_front();
               if (rsp_red !== e.red) begin
                  $display("%0t: red exp %h got %h", $time, e.red, rsp_red);
                  error_count++;
               end
               if (rsp_green !== e.green) begin
                  $display("%0t: green exp %h got %h", $time, e.green, rsp_green);
                  error_count++;
               end
               if (rsp_blue !== e.blue) begin
                  $display("%0t: blue exp %h got %h", $time, e.blue, rsp_blue);
                  error_count++;
               end
               if (rsp_alpha !== e.alpha) begin
                  $display("%0t: alpha exp %h got %h", $time, e.alpha, rsp_alpha);
                  error_count++;
               end
               if (rsp_has_alpha !== e.has_alpha) begin
                  $display("%0t: has_alpha exp %b got %b", $time, e.has_alpha,
                           rsp_has_alpha);
                  error_count++;
               end
            end
         end
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0);
   endtask

   task automatic test_directed();
      set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, 1'b1);
      send_pixel(32'h0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h1234_5678);
      send_pixel(32'h8080_8080);
      set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0, 1'b0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hABCD_0000);
      send_pixel(32'h0000_F81F);
      // masks above bit 15 in 16-bit mode, non-contiguous, full width
      set_format(32'hFFFF_FFFF, 32'h000F_F000, 32'hA500_0005, 32'h8000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_5A5A);
      set_format(32'hFFFF_FFFF, 32'h0000_0001, 32'hA500_0005, 32'h8000_0000, 1'b1);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h8000_0001);
      send_pixel(32'h7FFF_FFFE);
      send_pixel(32'hA500_0004);
      // out-of-range register index must be ignored
      drop_valid();
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_IDX_W'(7);
      csr_data <= 32'h0;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      send_pixel(32'hFFFF_FFFF);
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0)
            set_format(random_mask(), random_mask(), random_mask(), random_mask(),
                       1'($urandom_range(1)));
         send_pixel($urandom());
         if (n == count / 2) begin
            drop_valid();
            wait (expected_pixels.size() == 0);
         end
      end
   endtask

   initial begin
      error_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_word = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mask_red = '0;
      mask_green = '0;
      mask_blue = '0;
      mask_alpha = '0;
      pix_wide = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random_phase(0, 0, 260);
      test_random_phase(55, 0, 260);
      test_random_phase(0, 55, 260);
      test_random_phase(36, 36, 260);
      drop_valid();
      idle_pct = 0;
      stall_pct = 0;
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bpu_pkg.sv
hdl/bpu_lane.sv
hdl/bitfield_pixel_unpacker.sv
tb/tb.sv
